@@ hdl/bdpc_pkg.sv @@
// bdpc_pkg: shared types and constants for the button debounce and press classifier
// no dependencies; imported by bdpc_button and button_debounce_press_classifier
`default_nettype none

package bdpc_pkg;

  // number of buttons handled by the block
  localparam int unsigned BUTTONS = 4;

  // fixed field widths
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned RAW_W     = 4;
  localparam int unsigned INDEX_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // width wide enough to compare a button number against the index field
  localparam int unsigned SEL_W = 5;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_reg_t;

  // timing settings shared by all button cells
  typedef struct packed {
    logic [TIME_W-1:0] settle_time;
    logic [TIME_W-1:0] long_press_time;
  } timing_t;

  // per-button control for one processed word
  typedef struct packed {
    logic tick;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/bdpc_button.sv @@
// bdpc_button: debounce and press classification state of one button
// depends on bdpc_pkg for the timing and control structs
`default_nettype none

module bdpc_button (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire bdpc_pkg::timing_t         timing,
  input  wire bdpc_pkg::cell_ctrl_t      ctrl,
  input  wire logic [bdpc_pkg::STAMP_W-1:0] now_ms,
  input  wire logic                      raw,
  output bdpc_pkg::event_t               pending
);
  import bdpc_pkg::*;

  logic               raw_prev;
  logic               stable;
  logic [STAMP_W-1:0] change_stamp;
  logic [STAMP_W-1:0] press_stamp;
  logic               long_done;
  event_t             pending_event;

  logic               raw_changed;
  logic [STAMP_W-1:0] change_stamp_next;
  logic [STAMP_W-1:0] since_change;
  logic [STAMP_W-1:0] since_press;
  logic               settled;
  logic               press_edge;
  logic               long_fire;
  logic               short_fire;

  // raw tracking and debounce window, differences wrap mod 2^32
  always_comb begin
    raw_changed       = raw != raw_prev;
    change_stamp_next = raw_changed ? now_ms : change_stamp;
    since_change      = now_ms - change_stamp_next;
    since_press       = now_ms - press_stamp;
    settled           = since_change >= {{(STAMP_W-TIME_W){1'b0}}, timing.settle_time};
    press_edge        = settled && !raw && stable;
    long_fire         = settled && !raw && !stable && !long_done &&
                        (since_press >= {{(STAMP_W-TIME_W){1'b0}}, timing.long_press_time});
    short_fire        = settled && raw && !stable && !long_done;
  end

  // state update on a tick, clear on a read of this button
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev      <= 1'b1;
      stable        <= 1'b1;
      change_stamp  <= '0;
      press_stamp   <= '0;
      long_done     <= 1'b0;
      pending_event <= EV_NONE;
    end else if (ctrl.tick) begin
      raw_prev     <= raw;
      change_stamp <= change_stamp_next;
      if (settled) begin
        stable <= raw;
      end
      if (press_edge) begin
        press_stamp <= now_ms;
        long_done   <= 1'b0;
      end
      if (long_fire) begin
        long_done     <= 1'b1;
        pending_event <= EV_LONG;
      end else if (short_fire) begin
        pending_event <= EV_SHORT;
      end
    end else if (ctrl.clear) begin
      pending_event <= EV_NONE;
    end
  end

  assign pending = pending_event;

endmodule

`default_nettype wire

@@ hdl/button_debounce_press_classifier.sv @@
// button_debounce_press_classifier: top level with input stage, button cells, result register
// depends on bdpc_pkg and bdpc_button
`default_nettype none

// Debounces and classifies BUTTONS active-low buttons. A tick word (opcode 0) carries the
// millisecond time and raw levels and updates every button at once; a read word (opcode 1)
// returns the pending event of button_index (none when out of range) and clears it. One word
// is accepted per clock cycle while in_stall is low; it passes through the input register,
// where all button cells update in parallel, and its result then waits in the result
// register until taken. in_stall is high during reset and otherwise only when both registers
// are full and out_stall is high. Timing registers are written through cfg_write, cfg_index
// and cfg_data; the user must write them only while idle, as the block does not enforce it.
module button_debounce_press_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdpc_pkg::TIME_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          opcode,
  input  wire logic [bdpc_pkg::STAMP_W-1:0]   now_ms,
  input  wire logic [bdpc_pkg::RAW_W-1:0]     raw_levels,
  input  wire logic [bdpc_pkg::INDEX_W-1:0]   button_index,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         event_code
);
  import bdpc_pkg::*;

  timing_t            timing;

  logic               s1_valid;
  opcode_t            s1_opcode;
  logic [STAMP_W-1:0] s1_now;
  logic [RAW_W-1:0]   s1_raw;
  logic [INDEX_W-1:0] s1_index;

  logic               advance;
  logic               s1_fire;
  logic               in_fire;

  cell_ctrl_t         ctrl [BUTTONS];
  event_t             pending [BUTTONS];
  logic [BUTTONS-1:0] clear_vec;
  event_t             read_event;
  event_t             event_code_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.settle_time     <= TIME_W'(50);
      timing.long_press_time <= TIME_W'(1000);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DEBOUNCE:   timing.settle_time     <= cfg_data;
        CFG_LONG_PRESS: timing.long_press_time <= cfg_data;
        default:        ;
      endcase
    end
  end

  // handshake: input stage moves on whenever the result register is free or drains
  assign advance  = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && advance;
  assign in_stall = rst || (s1_valid && !advance);
  assign in_fire  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance || !s1_valid) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode <= opcode_t'(opcode);
      s1_now    <= now_ms;
      s1_raw    <= raw_levels;
      s1_index  <= button_index;
    end
  end

  // button cells
  for (genvar b = 0; b < BUTTONS; b++) begin : g_button
    logic raw_bit;

    if (b < RAW_W) begin : g_raw
      assign raw_bit = s1_raw[b];
    end else begin : g_zero
      assign raw_bit = 1'b0;
    end

    assign clear_vec[b]  = s1_fire && (s1_opcode == OP_READ) &&
                           ({{(SEL_W-INDEX_W){1'b0}}, s1_index} == SEL_W'(b));
    assign ctrl[b].tick  = s1_fire && (s1_opcode == OP_TICK);
    assign ctrl[b].clear = clear_vec[b];

    bdpc_button u_button (
      .clk     (clk),
      .rst     (rst),
      .timing  (timing),
      .ctrl    (ctrl[b]),
      .now_ms  (s1_now),
      .raw     (raw_bit),
      .pending (pending[b])
    );
  end

  // read select, none for an index past the last button
  always_comb begin
    read_event = EV_NONE;
    for (int b = 0; b < BUTTONS; b++) begin
      if ({{(SEL_W-INDEX_W){1'b0}}, s1_index} == SEL_W'(b)) begin
        read_event = pending[b];
      end
    end
    event_code_next = (s1_opcode == OP_READ) ? read_event : EV_NONE;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      event_code <= event_code_next;
    end
  end

  // checks
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a full pipeline");

  a_one_clear: assert property (@(posedge clk) disable iff (rst) $onehot0(clear_vec))
    else $error("more than one button cleared");

  a_event_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_code != 2'd3))
    else $error("illegal event code");

  a_tick_no_event: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_opcode == OP_TICK) |=> (out_valid && event_code == EV_NONE))
    else $error("tick word produced an event");

endmodule

`default_nettype wire

@@ tb/bdpc_checker.sv @@
`timescale 1ns / 100ps
// bdpc_checker: watches the config port and both word channels of the press classifier,
// keeps its own copy of the per-button state and checks every result word in order
// depends on bdpc_pkg for field widths, event codes, opcodes and register indexes

module bdpc_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [bdpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdpc_pkg::TIME_W-1:0]    cfg_data,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic                           opcode,
  input  wire logic [bdpc_pkg::STAMP_W-1:0]   now_ms,
  input  wire logic [bdpc_pkg::RAW_W-1:0]     raw_levels,
  input  wire logic [bdpc_pkg::INDEX_W-1:0]   button_index,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [1:0]                     event_code,
  output int                                  fail_count,
  output int                                  outstanding,
  output int                                  checked_count,
  output int                                  short_count,
  output int                                  long_count
);
  import bdpc_pkg::*;

  // shadow timing settings
  logic [TIME_W-1:0] settle_ms;
  logic [TIME_W-1:0] long_ms;

  // shadow per-button state
  logic               raw_seen   [BUTTONS];
  logic               stable_lvl [BUTTONS];
  logic [STAMP_W-1:0] change_at  [BUTTONS];
  logic [STAMP_W-1:0] press_at   [BUTTONS];
  logic               long_seen  [BUTTONS];
  event_t             held_event [BUTTONS];

  // events still owed by the block, oldest first
  event_t expected_events[$];

  // debounce and classify all buttons for one tick word
  task automatic classify_tick(input logic [STAMP_W-1:0] stamp,
                               input logic [RAW_W-1:0] levels);
    logic               lvl;
    logic [STAMP_W-1:0] since_change;
    logic [STAMP_W-1:0] since_press;
    for (int b = 0; b < BUTTONS; b++) begin
      lvl = levels[b];
      if (lvl != raw_seen[b]) begin
        change_at[b] = stamp;
        raw_seen[b]  = lvl;
      end
      since_change = stamp - change_at[b];
      // still bouncing: only the raw tracking above applies
      if (since_change >= {16'd0, settle_ms}) begin
        // stable press edge re-arms long detection
        if (!lvl && stable_lvl[b]) begin
          press_at[b]  = stamp;
          long_seen[b] = 1'b0;
        end
        since_press = stamp - press_at[b];
        // held low long enough, fires once per press
        if (!lvl && !stable_lvl[b] && !long_seen[b] &&
            since_press >= {16'd0, long_ms}) begin
          held_event[b] = EV_LONG;
          long_seen[b]  = 1'b1;
        end
        // release before a long event counts as short
        if (lvl && !stable_lvl[b] && !long_seen[b])
          held_event[b] = EV_SHORT;
        stable_lvl[b] = lvl;
      end
    end
  endtask

  // fetch and clear the pending event of one button
  function automatic event_t take_event(input logic [INDEX_W-1:0] idx);
    event_t ev;
    ev = EV_NONE;
    if (int'(idx) < BUTTONS) begin
      ev              = held_event[idx];
      held_event[idx] = EV_NONE;
    end
    return ev;
  endfunction

  always @(posedge clk) begin
    event_t want;
    if (rst) begin
      settle_ms = 16'd50;
      long_ms   = 16'd1000;
      for (int b = 0; b < BUTTONS; b++) begin
        raw_seen[b]   = 1'b1;
        stable_lvl[b] = 1'b1;
        change_at[b]  = '0;
        press_at[b]   = '0;
        long_seen[b]  = 1'b0;
        held_event[b] = EV_NONE;
      end
      expected_events.delete();
      fail_count    <= 0;
      checked_count <= 0;
      short_count   <= 0;
      long_count    <= 0;
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          CFG_DEBOUNCE:   settle_ms = cfg_data;
          CFG_LONG_PRESS: long_ms   = cfg_data;
          default: ;
        endcase
      end

      // result word against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result word %0d with nothing expected", $realtime, event_code);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_events.pop_front();
          if (event_code !== want) begin
            if (fail_count < 10)
              $display("%0t: event_code expected %0d got %0d", $realtime, want, event_code);
            fail_count <= fail_count + 1;
          end
          checked_count <= checked_count + 1;
          if (event_code === EV_SHORT) short_count <= short_count + 1;
          if (event_code === EV_LONG)  long_count  <= long_count + 1;
        end
      end

      // accepted input word
      if (in_valid && !in_stall) begin
        if (opcode == OP_READ) begin
          expected_events.push_back(take_event(button_index));
        end else begin
          classify_tick(now_ms, raw_levels);
          expected_events.push_back(EV_NONE);
        end
      end
    end
    outstanding <= expected_events.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// testbench: stimulus and verdict for button_debounce_press_classifier
// depends on bdpc_pkg, the block and bdpc_checker, which predicts and compares

module testbench;
  import bdpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [TIME_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 opcode;
  logic [STAMP_W-1:0]   now_ms;
  logic [RAW_W-1:0]     raw_levels;
  logic [INDEX_W-1:0]   button_index;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           event_code;

  int fail_count;
  int outstanding;
  int checked_count;
  int short_count;
  int long_count;

  // stimulus bookkeeping
  int               cycle_count = 0;
  int               burst_left;
  int               word_count;
  int               setting_count;
  int               stall_kind = 0;
  int               stall_left = 0;
  int               debounce_cur;
  int               long_cur;
  logic [STAMP_W-1:0] clock_ms;
  logic [RAW_W-1:0]   intent;
  int               bounce_left [BUTTONS];

  button_debounce_press_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .now_ms       (now_ms),
    .raw_levels   (raw_levels),
    .button_index (button_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_code   (event_code)
  );

  bdpc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .now_ms        (now_ms),
    .raw_levels    (raw_levels),
    .button_index  (button_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_code    (event_code),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .short_count   (short_count),
    .long_count    (long_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[button_debounce_press_classifier] ERROR");
      $finish;
    end
  end

  // receiver stall pattern: free, light, heavy or periodic stretches
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 60);
    end
    stall_left = stall_left - 1;
    case (stall_kind)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= stall_left[2];
    endcase
  end

  // send one word, in bursts with random gaps, and wait for its acceptance
  task automatic send_word(input opcode_t op, input logic [STAMP_W-1:0] stamp,
                           input logic [RAW_W-1:0] levels,
                           input logic [INDEX_W-1:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left = burst_left - 1;
    in_valid     <= 1'b1;
    opcode       <= op;
    now_ms       <= stamp;
    raw_levels   <= levels;
    button_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    word_count = word_count + 1;
  endtask

  task automatic tick(input logic [STAMP_W-1:0] stamp, input logic [RAW_W-1:0] levels);
    send_word(OP_TICK, stamp, levels, INDEX_W'($urandom));
  endtask

  task automatic read_event(input logic [INDEX_W-1:0] idx);
    send_word(OP_READ, $urandom, RAW_W'($urandom), idx);
  endtask

  // hold off the sender until every expected result word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write both timing registers while the block is idle
  task automatic set_timing(input int deb, input int lng);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_data  <= TIME_W'(deb);
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_data  <= TIME_W'(lng);
    @(posedge clk);
    cfg_write <= 1'b0;
    debounce_cur  = deb;
    long_cur      = lng;
    setting_count = setting_count + 1;
  endtask

  // presses and releases with contact bounce, reads mixed in, some noise
  task automatic run_random(input int n_words);
    int               pick;
    logic [RAW_W-1:0] levels;
    for (int n = 0; n < n_words; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        read_event(INDEX_W'($urandom_range(0, 7)));
      end else if (pick < 30) begin
        // noise: arbitrary time and levels
        clock_ms = $urandom;
        tick(clock_ms, RAW_W'($urandom));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 4)
          clock_ms = clock_ms + $urandom_range(0, 3);
        else if (pick < 8)
          clock_ms = clock_ms + $urandom_range(1, debounce_cur + 1);
        else
          clock_ms = clock_ms + $urandom_range(1, long_cur + debounce_cur + 2);
        for (int b = 0; b < BUTTONS; b++) begin
          if ($urandom_range(0, 99) < 15) begin
            intent[b]      = ~intent[b];
            bounce_left[b] = $urandom_range(0, 3);
          end
        end
        levels = intent;
        for (int b = 0; b < BUTTONS; b++) begin
          if (bounce_left[b] > 0) begin
            levels[b]      = $urandom_range(0, 1);
            bounce_left[b] = bounce_left[b] - 1;
          end
        end
        tick(clock_ms, levels);
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = CFG_DEBOUNCE;
    cfg_data      = '0;
    in_valid      = 1'b0;
    opcode        = OP_TICK;
    now_ms        = '0;
    raw_levels    = '1;
    button_index  = '0;
    burst_left    = 0;
    word_count    = 0;
    setting_count = 1;
    debounce_cur  = 50;
    long_cur      = 1000;
    clock_ms      = '0;
    intent        = '1;
    for (int b = 0; b < BUTTONS; b++) bounce_left[b] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: nothing pending after reset, in and out of range
    read_event(3'd0);
    read_event(3'd3);
    read_event(3'd4);
    read_event(3'd7);
    // long press on button 0, debounce edges and long threshold edges
    tick(32'd0, 4'hF);
    tick(32'd10, 4'hE);
    tick(32'd59, 4'hE);
    tick(32'd60, 4'hE);
    tick(32'd1059, 4'hE);
    tick(32'd1060, 4'hE);
    read_event(3'd0);
    read_event(3'd0);
    // release after a long event gives no short event
    tick(32'd1100, 4'hF);
    tick(32'd1150, 4'hF);
    read_event(3'd0);
    // short press on button 1, read with junk in the ignored fields
    tick(32'd1200, 4'hD);
    tick(32'd1250, 4'hD);
    tick(32'd1300, 4'hF);
    tick(32'd1350, 4'hF);
    send_word(OP_READ, 32'hFFFF_FFFF, 4'h0, 3'd1);
    // all buttons pressed at once with a bounce
    tick(32'd1400, 4'h0);
    tick(32'd1405, 4'h5);
    tick(32'd1410, 4'h0);
    tick(32'd1460, 4'h0);
    clock_ms = 32'd1460;
    intent   = 4'h0;

    // random phases over several timing settings
    drain_results();
    run_random(80);
    set_timing(0, 0);
    run_random(100);
    set_timing(65535, 65535);
    run_random(70);
    set_timing(3, 20);
    clock_ms = 32'hFFFF_F000;
    run_random(60);
    drain_results();
    run_random(60);
    set_timing(0, 65535);
    run_random(50);
    set_timing($urandom_range(0, 200), $urandom_range(0, 2000));
    run_random(90);
    set_timing($urandom_range(0, 20), $urandom_range(0, 100));
    run_random(90);

    // wait for the last results, bounded
    in_valid <= 1'b0;
    for (int w = 0; w < 5000 && outstanding != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d words over %0d timing settings", word_count, setting_count);
    $display("checked %0d result words: %0d short and %0d long presses read back",
             checked_count, short_count, long_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[button_debounce_press_classifier] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, outstanding);
      $display("[button_debounce_press_classifier] ERROR");
    end
    $finish;
  end

endmodule
